// ===== rtl/v3a_pkg.sv =====
// shared constants, types and saturation helper for the vector alu
package v3a_pkg;

  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;

  localparam int PROD_W      = 2 * WORD_BITS;
  localparam int SAT_W       = (2 * WORD_BITS + 4 > 2 * FRAC_BITS + 8) ?
                               2 * WORD_BITS + 4 : 2 * FRAC_BITS + 8;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int NRM_W       = FRAC_BITS + 2;
  localparam int CPROD_W     = 2 * NRM_W;
  localparam int SQ_REM_W    = WORD_BITS + 2;
  localparam int SQ_CUR_W    = WORD_BITS + 4;
  localparam int ROOT_STAGES = WORD_BITS;
  localparam int NORM_STAGES = QUO_W;

  localparam logic signed [SAT_W-1:0] SAT_MAX =
    {{(SAT_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SAT_MIN =
    {{(SAT_W - WORD_BITS + 1){1'b1}}, {(WORD_BITS - 1){1'b0}}};

  typedef enum logic [3:0] {
    K_COPY  = 4'd0,
    K_ADD   = 4'd1,
    K_SUB   = 4'd2,
    K_FROM  = 4'd3,
    K_SCALE = 4'd4,
    K_DOT   = 4'd5,
    K_CROSS = 4'd6,
    K_LEN   = 4'd7,
    K_NORM  = 4'd8,
    K_COS   = 4'd9,
    K_REFL  = 4'd10,
    K_EQ    = 4'd11
  } kind_e;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 ovf;
  } sat_t;

  typedef struct packed {
    kind_e                     kind;
    logic [2:0][WORD_BITS-1:0] vec;
    logic [WORD_BITS-1:0]      sc;
    logic                      eq;
    logic                      flt;
  } res_t;

  // magnitudes and signs of a (index 0) and b (index 1) for normalizing
  typedef struct packed {
    res_t                           res;
    logic [1:0][2:0]                neg;
    logic [1:0][2:0][WORD_BITS-1:0] mag;
  } carry_t;

  typedef struct packed {
    carry_t                     c;
    logic [1:0][PROD_W-1:0]     rad;
    logic [1:0][SQ_REM_W-1:0]   rem;
    logic [1:0][WORD_BITS-1:0]  root;
  } root_t;

  typedef struct packed {
    carry_t                         c;
    logic [1:0][WORD_BITS-1:0]      len;
    logic [1:0][2:0][WORD_BITS-1:0] rem;
    logic [1:0][2:0][QUO_W-1:0]     low;
    logic [1:0][2:0][QUO_W-1:0]     quo;
  } norm_t;

  function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[WORD_BITS-1:0];
      r.ovf = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[WORD_BITS-1:0];
      r.ovf = 1'b1;
    end else begin
      r.val = v[WORD_BITS-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== rtl/v3a_front.sv =====
// front stages: products, sums, saturation and the reflect update
module v3a_front
  import v3a_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  kind_e                     kind_i,
  input  logic [2:0][WORD_BITS-1:0] a_i,
  input  logic [2:0][WORD_BITS-1:0] b_i,
  input  logic [WORD_BITS-1:0]      t_i,
  output logic                      valid_o,
  output root_t                     data_o
);

  // stage 1
  logic                        v1_q;
  logic signed [PROD_W-1:0]    p1_d [6];
  logic signed [PROD_W-1:0]    p1_q [6];
  logic signed [WORD_BITS-1:0] a1_q [3];
  logic signed [WORD_BITS-1:0] b1_q [3];
  res_t                        r1_d, r1_q;

  always_comb begin
    logic signed [WORD_BITS-1:0] av [3];
    logic signed [WORD_BITS-1:0] bv [3];
    logic signed [WORD_BITS-1:0] opl [6];
    logic signed [WORD_BITS-1:0] opr [6];
    logic signed [SAT_W-1:0]     dw;
    logic                        eqv;
    sat_t                        st;
    dw = '0;
    st = '0;
    for (int k = 0; k < 3; k++) begin
      av[k] = $signed(a_i[k]);
      bv[k] = $signed(b_i[k]);
    end
    for (int k = 0; k < 6; k++) begin
      opl[k] = '0;
      opr[k] = '0;
    end
    case (kind_i)
      K_CROSS: begin
        opl[0] = av[1]; opr[0] = bv[2];
        opl[1] = av[2]; opr[1] = bv[1];
        opl[2] = av[2]; opr[2] = bv[0];
        opl[3] = av[0]; opr[3] = bv[2];
        opl[4] = av[0]; opr[4] = bv[1];
        opl[5] = av[1]; opr[5] = bv[0];
      end
      K_COS: begin
        for (int k = 0; k < 3; k++) begin
          opl[k] = av[k]; opr[k] = av[k];
          opl[k+3] = bv[k]; opr[k+3] = bv[k];
        end
      end
      K_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          opl[k] = av[k]; opr[k] = $signed(t_i);
        end
      end
      K_LEN, K_NORM: begin
        for (int k = 0; k < 3; k++) begin
          opl[k] = av[k]; opr[k] = av[k];
        end
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          opl[k] = av[k]; opr[k] = bv[k];
        end
      end
    endcase
    for (int k = 0; k < 6; k++) p1_d[k] = PROD_W'(opl[k]) * PROD_W'(opr[k]);

    r1_d      = '0;
    r1_d.kind = kind_i;
    eqv       = 1'b1;
    for (int k = 0; k < 3; k++) begin
      case (kind_i)
        K_COPY: r1_d.vec[k] = a_i[k];
        K_ADD: begin
          st = sat_word(SAT_W'(av[k]) + SAT_W'(bv[k]));
          r1_d.vec[k] = st.val;
          r1_d.flt    = r1_d.flt | st.ovf;
        end
        K_SUB: begin
          st = sat_word(SAT_W'(av[k]) - SAT_W'(bv[k]));
          r1_d.vec[k] = st.val;
          r1_d.flt    = r1_d.flt | st.ovf;
        end
        K_FROM: begin
          st = sat_word(SAT_W'(bv[k]) - SAT_W'(av[k]));
          r1_d.vec[k] = st.val;
          r1_d.flt    = r1_d.flt | st.ovf;
        end
        K_EQ: begin
          dw = SAT_W'(av[k]) - SAT_W'(bv[k]);
          if (dw < 0) dw = -dw;
          if (!(dw < SAT_W'($signed(t_i)))) eqv = 1'b0;
        end
        default: ;
      endcase
    end
    if (kind_i == K_EQ) r1_d.eq = eqv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      p1_q <= p1_d;
      for (int k = 0; k < 3; k++) begin
        a1_q[k] <= $signed(a_i[k]);
        b1_q[k] <= $signed(b_i[k]);
      end
      r1_q <= r1_d;
    end
  end

  // stage 2: sums and cross differences
  logic                        v2_q;
  logic signed [SAT_W-1:0]     e2_d [3];
  logic signed [SAT_W-1:0]     e2_q [3];
  logic signed [SAT_W-1:0]     sa2_q, sb2_q;
  logic signed [WORD_BITS-1:0] a2_q [3];
  logic signed [WORD_BITS-1:0] b2_q [3];
  res_t                        r2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (r1_q.kind == K_CROSS) e2_d[k] = SAT_W'(p1_q[2*k]) - SAT_W'(p1_q[2*k+1]);
      else                      e2_d[k] = SAT_W'(p1_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      e2_q  <= e2_d;
      sa2_q <= SAT_W'(p1_q[0]) + SAT_W'(p1_q[1]) + SAT_W'(p1_q[2]);
      sb2_q <= SAT_W'(p1_q[3]) + SAT_W'(p1_q[4]) + SAT_W'(p1_q[5]);
      a2_q  <= a1_q;
      b2_q  <= b1_q;
      r2_q  <= r1_q;
    end
  end

  // stage 3: shift back and saturate
  logic                        v3_q;
  carry_t                      c3_d, c3_q;
  logic signed [WORD_BITS-1:0] d3_d, d3_q;
  logic signed [SAT_W-1:0]     sa3_q, sb3_q;
  logic signed [WORD_BITS-1:0] a3_q [3];
  logic signed [WORD_BITS-1:0] b3_q [3];

  always_comb begin
    sat_t st;
    sat_t sd;
    c3_d.res = r2_q;
    sd       = sat_word(sa2_q >>> FRAC_BITS);
    d3_d     = $signed(sd.val);
    for (int k = 0; k < 3; k++) begin
      st = sat_word(e2_q[k] >>> FRAC_BITS);
      if (r2_q.kind == K_SCALE || r2_q.kind == K_CROSS) begin
        c3_d.res.vec[k] = st.val;
        c3_d.res.flt    = c3_d.res.flt | st.ovf;
      end
      c3_d.neg[0][k] = a2_q[k][WORD_BITS-1];
      c3_d.neg[1][k] = b2_q[k][WORD_BITS-1];
      c3_d.mag[0][k] = a2_q[k][WORD_BITS-1] ? (~a2_q[k] + 1'b1) : a2_q[k];
      c3_d.mag[1][k] = b2_q[k][WORD_BITS-1] ? (~b2_q[k] + 1'b1) : b2_q[k];
    end
    if (r2_q.kind == K_DOT) begin
      c3_d.res.sc  = sd.val;
      c3_d.res.flt = sd.ovf;
    end
    if (r2_q.kind == K_REFL) c3_d.res.flt = sd.ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      c3_q  <= c3_d;
      d3_q  <= d3_d;
      sa3_q <= sa2_q;
      sb3_q <= sb2_q;
      a3_q  <= a2_q;
      b3_q  <= b2_q;
    end
  end

  // stage 4: saturated dot times b for reflect
  logic                        v4_q;
  logic signed [PROD_W-1:0]    p4_q [3];
  logic signed [WORD_BITS-1:0] a4_q [3];
  carry_t                      c4_q;
  logic signed [SAT_W-1:0]     sa4_q, sb4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      for (int k = 0; k < 3; k++) p4_q[k] <= PROD_W'(d3_q) * PROD_W'(b3_q[k]);
      a4_q  <= a3_q;
      c4_q  <= c3_q;
      sa4_q <= sa3_q;
      sb4_q <= sb3_q;
    end
  end

  // stage 5: a minus twice the product, then seed the root pipeline
  logic  v5_q;
  root_t d5_d, d5_q;

  always_comb begin
    logic signed [SAT_W-1:0] n;
    logic signed [SAT_W-1:0] s;
    sat_t                    st;
    d5_d.c = c4_q;
    for (int k = 0; k < 3; k++) begin
      n  = -(SAT_W'(p4_q[k]) <<< 1);
      s  = SAT_W'(a4_q[k]) + (n >>> FRAC_BITS);
      st = sat_word(s);
      if (c4_q.res.kind == K_REFL) begin
        d5_d.c.res.vec[k] = st.val;
        d5_d.c.res.flt    = d5_d.c.res.flt | st.ovf;
      end
    end
    d5_d.rad[0] = sa4_q[PROD_W-1:0];
    d5_d.rad[1] = sb4_q[PROD_W-1:0];
    d5_d.rem    = '0;
    d5_d.root   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (v4_q) d5_q <= d5_d;
  end

  assign valid_o = v5_q;
  assign data_o  = d5_q;

endmodule

// ===== rtl/v3a_root_stage.sv =====
// one digit of the square roots of |a|^2 and |b|^2
module v3a_root_stage
  import v3a_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  root_t data_i,
  output logic  valid_o,
  output root_t data_o
);

  logic  valid_q;
  root_t data_d, data_q;

  always_comb begin
    logic [SQ_CUR_W-1:0] cur;
    logic [SQ_CUR_W-1:0] trial;
    logic [SQ_CUR_W-1:0] diff;
    data_d = data_i;
    for (int v = 0; v < 2; v++) begin
      cur   = {data_i.rem[v], data_i.rad[v][PROD_W-1 -: 2]};
      trial = SQ_CUR_W'({data_i.root[v], 2'b01});
      diff  = cur - trial;
      if (cur >= trial) begin
        data_d.rem[v]  = diff[SQ_REM_W-1:0];
        data_d.root[v] = {data_i.root[v][WORD_BITS-2:0], 1'b1};
      end else begin
        data_d.rem[v]  = cur[SQ_REM_W-1:0];
        data_d.root[v] = {data_i.root[v][WORD_BITS-2:0], 1'b0};
      end
      data_d.rad[v] = data_i.rad[v] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/v3a_norm_stage.sv =====
// one quotient bit of the six component-by-length divisions
module v3a_norm_stage
  import v3a_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  norm_t data_i,
  output logic  valid_o,
  output norm_t data_o
);

  logic  valid_q;
  norm_t data_d, data_q;

  always_comb begin
    logic [WORD_BITS:0] rs;
    logic [WORD_BITS:0] lw;
    logic [WORD_BITS:0] diff;
    logic               ge;
    data_d = data_i;
    for (int v = 0; v < 2; v++) begin
      for (int k = 0; k < 3; k++) begin
        rs   = {data_i.rem[v][k], data_i.low[v][k][QUO_W-1]};
        lw   = {1'b0, data_i.len[v]};
        diff = rs - lw;
        ge   = (rs >= lw);
        data_d.rem[v][k] = ge ? diff[WORD_BITS-1:0] : rs[WORD_BITS-1:0];
        data_d.low[v][k] = data_i.low[v][k] << 1;
        data_d.quo[v][k] = {data_i.quo[v][k][QUO_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/v3a_back.sv =====
// back stages: length, normalize and cosine results, output register
module v3a_back
  import v3a_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  norm_t data_i,
  output logic  valid_o,
  output res_t  res_o
);

  logic                      v1_q;
  logic signed [CPROD_W-1:0] pc_d [3];
  logic signed [CPROD_W-1:0] pc_q [3];
  res_t                      r1_d, r1_q;
  logic                      z1_q;

  always_comb begin
    logic [NRM_W-1:0]        q;
    logic signed [NRM_W-1:0] na [3];
    logic signed [NRM_W-1:0] nb [3];
    sat_t                    st;
    st   = '0;
    r1_d = data_i.c.res;
    for (int k = 0; k < 3; k++) begin
      q     = {1'b0, data_i.quo[0][k]};
      na[k] = data_i.c.neg[0][k] ? -$signed(q) : $signed(q);
      q     = {1'b0, data_i.quo[1][k]};
      nb[k] = data_i.c.neg[1][k] ? -$signed(q) : $signed(q);
      pc_d[k] = CPROD_W'(na[k]) * CPROD_W'(nb[k]);
      if (data_i.c.res.kind == K_NORM && data_i.len[0] != '0) begin
        st = sat_word(SAT_W'(na[k]));
        r1_d.vec[k] = st.val;
        r1_d.flt    = r1_d.flt | st.ovf;
      end
    end
    if (data_i.c.res.kind == K_NORM && data_i.len[0] == '0) r1_d.flt = 1'b1;
    if (data_i.c.res.kind == K_LEN) begin
      if (data_i.len[0][WORD_BITS-1]) begin
        r1_d.sc  = SAT_MAX[WORD_BITS-1:0];
        r1_d.flt = 1'b1;
      end else begin
        r1_d.sc = data_i.len[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pc_q <= pc_d;
      r1_q <= r1_d;
      z1_q <= (data_i.len[0] == '0) || (data_i.len[1] == '0);
    end
  end

  // cosine sum of unit-vector products
  logic v2_q;
  res_t r2_d, r2_q;

  always_comb begin
    logic signed [SAT_W-1:0] s;
    sat_t                    st;
    s    = SAT_W'(pc_q[0]) + SAT_W'(pc_q[1]) + SAT_W'(pc_q[2]);
    st   = sat_word(s >>> FRAC_BITS);
    r2_d = r1_q;
    if (r1_q.kind == K_COS) begin
      if (z1_q) begin
        r2_d.flt = 1'b1;
      end else begin
        r2_d.sc  = st.val;
        r2_d.flt = st.ovf;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) r2_q <= r2_d;
  end

  assign valid_o = v2_q;
  assign res_o   = r2_q;

endmodule

// ===== rtl/vector3_alu.sv =====
// three-component fixed-point vector alu, fully pipelined
//
// channel   direction  strobe / handshake        payload
// command   in         start_i, busy_o           kind_i, a_*_i, b_*_i, scalar_in_i
// result    out        done_o                    out_*_o, equal_flag_o, fault_o
//
// one command per cycle; at Q16.16 each result passes the front stages, then the
// bit-per-stage square root and divide chains, then the back stages; every
// operation takes the same path so results leave in order
// busy_o stays low: the pipeline never stalls and the receiver cannot stall it
// reset clears only the valid bits, so no result strobes until a command enters
module vector3_alu
  import v3a_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [3:0]           kind_i,
  input  logic [WORD_BITS-1:0] a_x_i,
  input  logic [WORD_BITS-1:0] a_y_i,
  input  logic [WORD_BITS-1:0] a_z_i,
  input  logic [WORD_BITS-1:0] b_x_i,
  input  logic [WORD_BITS-1:0] b_y_i,
  input  logic [WORD_BITS-1:0] b_z_i,
  input  logic [WORD_BITS-1:0] scalar_in_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] out_x_o,
  output logic [WORD_BITS-1:0] out_y_o,
  output logic [WORD_BITS-1:0] out_z_o,
  output logic [WORD_BITS-1:0] out_scalar_o,
  output logic                 equal_flag_o,
  output logic                 fault_o
);

  logic [2:0][WORD_BITS-1:0] a_vec, b_vec;
  logic                      accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign a_vec  = {a_z_i, a_y_i, a_x_i};
  assign b_vec  = {b_z_i, b_y_i, b_x_i};

  logic [ROOT_STAGES:0] root_v;
  root_t                root_c [ROOT_STAGES+1];

  v3a_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .kind_i  (kind_e'(kind_i)),
    .a_i     (a_vec),
    .b_i     (b_vec),
    .t_i     (scalar_in_i),
    .valid_o (root_v[0]),
    .data_o  (root_c[0])
  );

  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_root
    v3a_root_stage u_root (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (root_v[g]),
      .data_i  (root_c[g]),
      .valid_o (root_v[g+1]),
      .data_o  (root_c[g+1])
    );
  end

  logic [NORM_STAGES:0] norm_v;
  norm_t                norm_c [NORM_STAGES+1];

  // seed each division: the quotient is known to fit QUO_W bits
  always_comb begin
    logic [WORD_BITS-1:0] m;
    norm_c[0].c   = root_c[ROOT_STAGES].c;
    norm_c[0].len = root_c[ROOT_STAGES].root;
    for (int v = 0; v < 2; v++) begin
      for (int k = 0; k < 3; k++) begin
        m = root_c[ROOT_STAGES].c.mag[v][k];
        norm_c[0].rem[v][k] = {1'b0, m[WORD_BITS-1:1]};
        norm_c[0].low[v][k] = {m[0], {FRAC_BITS{1'b0}}};
        norm_c[0].quo[v][k] = '0;
      end
    end
  end
  assign norm_v[0] = root_v[ROOT_STAGES];

  for (genvar g = 0; g < NORM_STAGES; g++) begin : g_norm
    v3a_norm_stage u_norm (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (norm_v[g]),
      .data_i  (norm_c[g]),
      .valid_o (norm_v[g+1]),
      .data_o  (norm_c[g+1])
    );
  end

  res_t res;

  v3a_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_v[NORM_STAGES]),
    .data_i  (norm_c[NORM_STAGES]),
    .valid_o (done_o),
    .res_o   (res)
  );

  assign out_x_o      = res.vec[0];
  assign out_y_o      = res.vec[1];
  assign out_z_o      = res.vec[2];
  assign out_scalar_o = res.sc;
  assign equal_flag_o = res.eq;
  assign fault_o      = res.flt;

endmodule
